>>> hdl/http_request_classifier_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the HTTP request classifier.
// Shared property wrappers with a clock, an active-low reset and a message.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_CLASSIFIER_CORE_MACROS_SVH
`define HTTP_REQUEST_CLASSIFIER_CORE_MACROS_SVH

// General form: explicit clock and active-low reset.
`define HRC_ASSERT_CLK(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Short form for a scope that has clk and arst_n.
`define HRC_ASSERT(name, prop, msg) \
	`HRC_ASSERT_CLK(name, clk, arst_n, prop, msg)

`endif

>>> hdl/hrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_pkg
// Types, codes and constant tables shared by the request classifier files.
// ----------------------------------------------------------------------------
package hrc_pkg;

	// Verdict codes, in order of precedence.
	typedef enum logic [3:0] {
		VERDICT_OK          = 4'd0,
		VERDICT_NO_BLANK    = 4'd1,
		VERDICT_NO_HEADERS  = 4'd2,
		VERDICT_MANY_WORDS  = 4'd3,
		VERDICT_FEW_WORDS   = 4'd4,
		VERDICT_BAD_METHOD  = 4'd5,
		VERDICT_BAD_VERSION = 4'd6,
		VERDICT_NO_HOST     = 4'd7,
		VERDICT_BAD_TARGET  = 4'd8
	} verdict_t;

	// Parser region within one request.
	typedef enum logic [1:0] {
		REGION_LINE        = 2'd0,
		REGION_HEADERS     = 2'd1,
		REGION_BODY        = 2'd2,
		REGION_BODY_EMPTY  = 2'd3
	} region_t;

	// Candidate words matched in the request line.
	localparam int unsigned NCAND       = 5;
	localparam int unsigned CAND_GET    = 0;
	localparam int unsigned CAND_POST   = 1;
	localparam int unsigned CAND_ROOT   = 2;
	localparam int unsigned CAND_INDEX  = 3;
	localparam int unsigned CAND_HTTP11 = 4;

	// Bits of the word check mask.
	localparam int unsigned CHECK_METHOD  = 0;
	localparam int unsigned CHECK_TARGET  = 1;
	localparam int unsigned CHECK_VERSION = 2;

	localparam logic [2:0] WORD_COUNT_MAX = 3'd4;
	localparam logic [3:0] CHAR_INDEX_MAX = 4'd15;
	localparam logic [1:0] HDR_COUNT_MAX  = 2'd3;
	localparam logic [2:0] HOST_LEN       = 3'd5;

	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_H     = 8'h48;

	// Last three bytes that precede the LF closing the blank line.
	localparam logic [23:0] CRLFCR = 24'h0D0A0D;

	// Status of the line-word tracker.
	typedef struct packed {
		logic [2:0] word_count;
		logic [2:0] checks;
	} line_stat_t;

	// Status of the header tracker.
	typedef struct packed {
		logic       host_found;
		logic [1:0] byte_count_nx;
	} hdr_stat_t;

	// Length of each candidate word.
	function automatic logic [3:0] cand_len(input int unsigned k);
		logic [3:0] len;
		case (k)
			CAND_GET:    len = 4'd3;
			CAND_POST:   len = 4'd4;
			CAND_ROOT:   len = 4'd1;
			CAND_INDEX:  len = 4'd11;
			CAND_HTTP11: len = 4'd8;
			default:     len = 4'd0;
		endcase
		return len;
	endfunction

	// Character of candidate k at position idx; zero past its end.
	function automatic logic [7:0] cand_char(input int unsigned k, input logic [3:0] idx);
		logic [7:0] ch;
		ch = 8'h00;
		case (k)
			CAND_GET: begin
				case (idx)
					4'd0:    ch = "G";
					4'd1:    ch = "E";
					4'd2:    ch = "T";
					default: ch = 8'h00;
				endcase
			end
			CAND_POST: begin
				case (idx)
					4'd0:    ch = "P";
					4'd1:    ch = "O";
					4'd2:    ch = "S";
					4'd3:    ch = "T";
					default: ch = 8'h00;
				endcase
			end
			CAND_ROOT: begin
				case (idx)
					4'd0:    ch = "/";
					default: ch = 8'h00;
				endcase
			end
			CAND_INDEX: begin
				case (idx)
					4'd0:    ch = "/";
					4'd1:    ch = "i";
					4'd2:    ch = "n";
					4'd3:    ch = "d";
					4'd4:    ch = "e";
					4'd5:    ch = "x";
					4'd6:    ch = ".";
					4'd7:    ch = "h";
					4'd8:    ch = "t";
					4'd9:    ch = "m";
					4'd10:   ch = "l";
					default: ch = 8'h00;
				endcase
			end
			CAND_HTTP11: begin
				case (idx)
					4'd0:    ch = "H";
					4'd1:    ch = "T";
					4'd2:    ch = "T";
					4'd3:    ch = "P";
					4'd4:    ch = "/";
					4'd5:    ch = "1";
					4'd6:    ch = ".";
					4'd7:    ch = "1";
					default: ch = 8'h00;
				endcase
			end
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// Character of "Host:" at position idx.
	function automatic logic [7:0] host_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0:    ch = "H";
			3'd1:    ch = "o";
			3'd2:    ch = "s";
			3'd3:    ch = "t";
			3'd4:    ch = ":";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// HTTP status number that goes with a verdict.
	function automatic logic [8:0] status_of(input verdict_t v);
		logic [8:0] s;
		case (v)
			VERDICT_OK:          s = 9'd200;
			VERDICT_NO_BLANK,
			VERDICT_NO_HEADERS,
			VERDICT_MANY_WORDS,
			VERDICT_FEW_WORDS:   s = 9'd400;
			VERDICT_BAD_METHOD:  s = 9'd501;
			VERDICT_BAD_VERSION: s = 9'd505;
			VERDICT_NO_HOST:     s = 9'd418;
			VERDICT_BAD_TARGET:  s = 9'd404;
			default:             s = 9'd400;
		endcase
		return s;
	endfunction

endpackage

>>> hdl/hrc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_in_if
// Byte stream channel: one request byte and its last-byte flag per transfer.
// ----------------------------------------------------------------------------
interface hrc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_request;

	modport source (output valid, output data_byte, output end_of_request, input ready);
	modport sink (input valid, input data_byte, input end_of_request, output ready);
endinterface

>>> hdl/hrc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_out_if
// Result channel: one verdict and its HTTP status number per transfer.
// ----------------------------------------------------------------------------
interface hrc_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] verdict;
	logic [8:0] status_number;

	modport source (output valid, output verdict, output status_number, input ready);
	modport sink (input valid, input verdict, input status_number, output ready);
endinterface

>>> hdl/hrc_line_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_line_unit
// Splits the request line into words and checks method, target and version.
// ----------------------------------------------------------------------------
module hrc_line_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               clear,
	input  logic [7:0]         data_byte,
	output hrc_pkg::line_stat_t stat
);

	logic                       inside_q, inside_nx;
	logic [2:0]                 word_count_q, word_count_nx;
	logic [3:0]                 char_index_q, char_index_nx;
	logic [hrc_pkg::NCAND-1:0]  cand_q, cand_nx;
	logic [2:0]                 checks_q, checks_nx;
	logic                       blank;
	logic [hrc_pkg::NCAND-1:0]  cand_ok;
	logic [3:0]                 idx_eff;
	logic [hrc_pkg::NCAND-1:0]  cand_eff;

	// Whitespace: space, or tab through carriage return.
	assign blank = (data_byte == hrc_pkg::CHAR_SPACE) ||
		((data_byte >= hrc_pkg::CHAR_TAB) && (data_byte <= hrc_pkg::CHAR_CR));

	// A candidate completes when it still matches and its length is reached.
	always_comb begin
		for (int unsigned k = 0; k < hrc_pkg::NCAND; k++) begin
			cand_ok[k] = cand_q[k] && (hrc_pkg::cand_len(k) == char_index_q);
		end
	end

	// Next word state for one request-line byte.
	always_comb begin
		inside_nx     = inside_q;
		word_count_nx = word_count_q;
		char_index_nx = char_index_q;
		cand_nx       = cand_q;
		checks_nx     = checks_q;
		idx_eff       = char_index_q;
		cand_eff      = cand_q;
		if (blank) begin
			if (inside_q) begin
				if (word_count_q == 3'd1 &&
					(cand_ok[hrc_pkg::CAND_GET] || cand_ok[hrc_pkg::CAND_POST])) begin
					checks_nx[hrc_pkg::CHECK_METHOD] = 1'b1;
				end else if (word_count_q == 3'd2 &&
					(cand_ok[hrc_pkg::CAND_ROOT] || cand_ok[hrc_pkg::CAND_INDEX])) begin
					checks_nx[hrc_pkg::CHECK_TARGET] = 1'b1;
				end else if (word_count_q == 3'd3 && cand_ok[hrc_pkg::CAND_HTTP11]) begin
					checks_nx[hrc_pkg::CHECK_VERSION] = 1'b1;
				end
				inside_nx = 1'b0;
			end
		end else begin
			if (!inside_q) begin
				inside_nx = 1'b1;
				if (word_count_q < hrc_pkg::WORD_COUNT_MAX) begin
					word_count_nx = word_count_q + 3'd1;
				end
				idx_eff  = 4'd0;
				cand_eff = '1;
			end
			for (int unsigned k = 0; k < hrc_pkg::NCAND; k++) begin
				if (idx_eff >= hrc_pkg::cand_len(k) ||
					hrc_pkg::cand_char(k, idx_eff) != data_byte) begin
					cand_nx[k] = 1'b0;
				end else begin
					cand_nx[k] = cand_eff[k];
				end
			end
			if (idx_eff < hrc_pkg::CHAR_INDEX_MAX) begin
				char_index_nx = idx_eff + 4'd1;
			end else begin
				char_index_nx = idx_eff;
			end
		end
	end

	// Word state registers; the end of a request returns them to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q     <= 1'b0;
			word_count_q <= 3'd0;
			char_index_q <= 4'd0;
			cand_q       <= '1;
			checks_q     <= 3'd0;
		end else if (clear) begin
			inside_q     <= 1'b0;
			word_count_q <= 3'd0;
			char_index_q <= 4'd0;
			cand_q       <= '1;
			checks_q     <= 3'd0;
		end else if (step) begin
			inside_q     <= inside_nx;
			word_count_q <= word_count_nx;
			char_index_q <= char_index_nx;
			cand_q       <= cand_nx;
			checks_q     <= checks_nx;
		end
	end

	assign stat.word_count = word_count_q;
	assign stat.checks     = checks_q;

endmodule

>>> hdl/hrc_header_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_header_unit
// Counts header bytes and searches the header region for "Host:".
// ----------------------------------------------------------------------------
module hrc_header_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              clear,
	input  logic [7:0]        data_byte,
	output hrc_pkg::hdr_stat_t stat
);

	logic [1:0] count_q, count_nx;
	logic [2:0] progress_q, progress_nx;
	logic       found_q, found_nx;
	logic [2:0] progress_inc;

	assign progress_inc = progress_q + 3'd1;

	// Saturating byte count and the "Host:" match progress.
	always_comb begin
		count_nx    = count_q;
		progress_nx = progress_q;
		found_nx    = found_q;
		if (count_q < hrc_pkg::HDR_COUNT_MAX) begin
			count_nx = count_q + 2'd1;
		end
		if (progress_q < hrc_pkg::HOST_LEN && hrc_pkg::host_char(progress_q) == data_byte) begin
			if (progress_inc == hrc_pkg::HOST_LEN) begin
				found_nx    = 1'b1;
				progress_nx = 3'd0;
			end else begin
				progress_nx = progress_inc;
			end
		end else begin
			progress_nx = (data_byte == hrc_pkg::CHAR_H) ? 3'd1 : 3'd0;
		end
	end

	// Header state registers; the end of a request returns them to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= 2'd0;
			progress_q <= 3'd0;
			found_q    <= 1'b0;
		end else if (clear) begin
			count_q    <= 2'd0;
			progress_q <= 3'd0;
			found_q    <= 1'b0;
		end else if (step) begin
			count_q    <= count_nx;
			progress_q <= progress_nx;
			found_q    <= found_nx;
		end
	end

	assign stat.host_found    = found_q;
	assign stat.byte_count_nx = count_nx;

endmodule

>>> hdl/http_request_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_classifier_core
// Classifies one HTTP request, fed byte by byte, into a verdict and status.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel carries one byte of request text per transfer, with
//   end_of_request set on the final byte. The result channel carries one
//   verdict and its HTTP status number for each request; bytes that are not
//   the last produce no transfer on it.
//   Throughput is one byte per cycle while no final byte waits behind a
//   pending verdict. Each byte is registered, then walks the small word and
//   header trackers; the verdict is loaded into the result register as the
//   final byte leaves the input register and is offered from then on.
//   The output register lets a new byte in while a verdict waits. If the
//   receiver stalls with a verdict pending, non-final bytes keep flowing,
//   and only a following final byte waits in the input register, which
//   then lowers ready until the verdict is transferred.
//   Reset clears all parser state to the start of a request line and drops
//   any pending byte or verdict. After each verdict the parser state returns
//   to that same start, ready for the next request.
// ----------------------------------------------------------------------------
module http_request_classifier_core (
	input logic          clk,
	input logic          arst_n,
	hrc_in_if.sink       request,
	hrc_out_if.source    result
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 last_s1;
	logic                 advance;
	hrc_pkg::region_t     region_q, region_nx;
	logic [23:0]          recent_q;
	hrc_pkg::line_stat_t  line_stat;
	hrc_pkg::hdr_stat_t   hdr_stat;
	hrc_pkg::verdict_t    verdict_nx;
	logic                 out_valid_q;
	hrc_pkg::verdict_t    verdict_q;
	logic [8:0]           status_q;
	logic                 line_step, hdr_step, finish;

	// The staged byte moves on unless it is final and the result is blocked.
	assign advance       = valid_s1 && (!last_s1 || !out_valid_q || result.ready);
	assign request.ready = !valid_s1 || advance;
	assign finish        = advance && last_s1;
	assign line_step     = advance && (region_q == hrc_pkg::REGION_LINE);
	assign hdr_step      = advance && (region_q == hrc_pkg::REGION_HEADERS);

	// Input stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (request.ready) begin
			valid_s1 <= request.valid;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (request.valid && request.ready) begin
			byte_s1 <= request.data_byte;
			last_s1 <= request.end_of_request;
		end
	end

	hrc_line_unit u_line (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (line_step),
		.clear     (finish),
		.data_byte (byte_s1),
		.stat      (line_stat)
	);

	hrc_header_unit u_header (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (hdr_step),
		.clear     (finish),
		.data_byte (byte_s1),
		.stat      (hdr_stat)
	);

	// Region transitions on CR LF and on the blank line.
	always_comb begin
		region_nx = region_q;
		case (region_q)
			hrc_pkg::REGION_LINE: begin
				if (recent_q[7:0] == hrc_pkg::CHAR_CR && byte_s1 == hrc_pkg::CHAR_LF) begin
					region_nx = hrc_pkg::REGION_HEADERS;
				end
			end
			hrc_pkg::REGION_HEADERS: begin
				if (recent_q == hrc_pkg::CRLFCR && byte_s1 == hrc_pkg::CHAR_LF) begin
					region_nx = (hdr_stat.byte_count_nx == 2'd2) ?
						hrc_pkg::REGION_BODY_EMPTY : hrc_pkg::REGION_BODY;
				end
			end
			default: region_nx = region_q;
		endcase
	end

	// Region and byte history registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q <= hrc_pkg::REGION_LINE;
			recent_q <= 24'd0;
		end else if (finish) begin
			region_q <= hrc_pkg::REGION_LINE;
			recent_q <= 24'd0;
		end else if (advance) begin
			region_q <= region_nx;
			recent_q <= {recent_q[15:0], byte_s1};
		end
	end

	// Verdict in order of precedence.
	always_comb begin
		if (region_nx == hrc_pkg::REGION_LINE || region_nx == hrc_pkg::REGION_HEADERS) begin
			verdict_nx = hrc_pkg::VERDICT_NO_BLANK;
		end else if (region_nx == hrc_pkg::REGION_BODY_EMPTY) begin
			verdict_nx = hrc_pkg::VERDICT_NO_HEADERS;
		end else if (line_stat.word_count > 3'd3) begin
			verdict_nx = hrc_pkg::VERDICT_MANY_WORDS;
		end else if (line_stat.word_count < 3'd3) begin
			verdict_nx = hrc_pkg::VERDICT_FEW_WORDS;
		end else if (!line_stat.checks[hrc_pkg::CHECK_METHOD]) begin
			verdict_nx = hrc_pkg::VERDICT_BAD_METHOD;
		end else if (!line_stat.checks[hrc_pkg::CHECK_VERSION]) begin
			verdict_nx = hrc_pkg::VERDICT_BAD_VERSION;
		end else if (!hdr_stat.host_found) begin
			verdict_nx = hrc_pkg::VERDICT_NO_HOST;
		end else if (!line_stat.checks[hrc_pkg::CHECK_TARGET]) begin
			verdict_nx = hrc_pkg::VERDICT_BAD_TARGET;
		end else begin
			verdict_nx = hrc_pkg::VERDICT_OK;
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (finish) begin
			verdict_q <= verdict_nx;
			status_q  <= hrc_pkg::status_of(verdict_nx);
		end
	end

	assign result.valid         = out_valid_q;
	assign result.verdict       = verdict_q;
	assign result.status_number = status_q;

endmodule

>>> hdl/hrc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_checker
// Port-level checks on the request classifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "http_request_classifier_core_macros.svh"

module hrc_checker (
	input logic       clk,
	input logic       arst_n,
	hrc_in_if.sink    request,
	hrc_out_if.source result
);

	logic        last_xfer;
	logic        status_ok;
	logic        result_wait;
	logic [12:0] result_word;

	// Transfer of the final byte of a request.
	assign last_xfer = request.valid && request.ready && request.end_of_request;

	// The status number must be the one that goes with a defined verdict code.
	assign status_ok = (result.verdict <= hrc_pkg::VERDICT_BAD_TARGET) &&
		(result.status_number == hrc_pkg::status_of(hrc_pkg::verdict_t'(result.verdict)));

	// A verdict offered but not taken, and its payload.
	assign result_wait = result.valid && !result.ready;
	assign result_word = {result.verdict, result.status_number};

	// A final byte always leads to a pending verdict.
	`HRC_ASSERT(a_last_gives_verdict, last_xfer |-> ##2 result.valid, "final byte gave no verdict")

	// A newly raised verdict comes from an earlier transfer of a final byte.
	`HRC_ASSERT(a_verdict_has_cause, $rose(result.valid) |-> $past(last_xfer, 2), "verdict with no cause")

	// The status number agrees with the verdict code.
	`HRC_ASSERT(a_status_matches, result.valid |-> status_ok, "status does not match verdict")

	// A stalled verdict holds.
	`HRC_ASSERT(a_result_holds, result_wait |=> (result.valid && $stable(result_word)), "stalled verdict changed")

endmodule

bind http_request_classifier_core hrc_checker u_hrc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.request (request),
	.result  (result)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the HTTP request classifier core. Request bytes are
// streamed in over the request channel with random gaps, and each verdict on
// the result channel is compared with its table row or a behavioral parser
// kept in step with every accepted byte. A directed table of requests comes
// first, then random requests, mostly well formed, some broken or noisy.
// ----------------------------------------------------------------------------
module tb;
	import hrc_pkg::*;

	localparam int RANDOM_BYTES    = 925;
	localparam int MIN_RANDOM_REQS = 20;
	localparam int HOLD_CYCLES     = 300;
	localparam int DRAIN_CYCLES    = 20;
	localparam int IDLE_PERCENT    = 35;

	// One expected verdict with its status number.
	typedef struct packed {
		verdict_t   verdict;
		logic [8:0] status;
	} verdict_rec_t;

	// One directed request; fixed rows carry their verdict, the rest are predicted.
	typedef struct {
		string      text;
		bit         fixed;
		verdict_t   verdict;
		logic [8:0] status;
	} probe_row_t;

	logic clk;
	logic arst_n;

	hrc_in_if  request ();
	hrc_out_if result ();

	http_request_classifier_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request),
		.result (result)
	);

	// Verdicts still owed by the block, oldest first.
	verdict_rec_t verdicts_due [$];
	logic [7:0]   req_bytes [$];
	int           mismatches;
	int           bytes_sent;
	bit           steady;
	bit           hold_off;

	// Parser state of the behavioral model.
	region_t    region;
	logic [23:0] recent;
	logic [1:0] hdr_cnt;
	logic [2:0] words;
	logic       in_word;
	logic [3:0] char_idx;
	logic [4:0] cands;
	logic [2:0] checks;
	logic [2:0] host_prog;
	logic       host_seen;

	string cand_word [NCAND] = '{"GET", "POST", "/", "/index.html", "HTTP/1.1"};
	string host_word = "Host:";
	logic [8:0] status_tab [0:8] = '{9'd200, 9'd400, 9'd400, 9'd400, 9'd400,
		9'd501, 9'd505, 9'd418, 9'd404};

	probe_row_t probe_rows [20] = '{
		'{"GET / HTTP/1.1\015\nHost: a\015\n\015\n", 1'b1, VERDICT_OK, 9'd200},
		'{"POST /index.html HTTP/1.1\015\nHost:x\015\n\015\n", 1'b1, VERDICT_OK, 9'd200},
		'{"GET / HTTP/1.1\015\n", 1'b1, VERDICT_NO_BLANK, 9'd400},
		'{"G", 1'b1, VERDICT_NO_BLANK, 9'd400},
		'{"GET / HTTP/1.1\015\n\015\n", 1'b1, VERDICT_NO_HEADERS, 9'd400},
		'{"GET / HTTP/1.1 x\015\nHost: a\015\n\015\n", 1'b1, VERDICT_MANY_WORDS, 9'd400},
		'{"GET /\015\nHost: a\015\n\015\n", 1'b1, VERDICT_FEW_WORDS, 9'd400},
		'{"PUT / HTTP/1.1\015\nHost: a\015\n\015\n", 1'b1, VERDICT_BAD_METHOD, 9'd501},
		'{"GET / HTTP/1.0\015\nHost: a\015\n\015\n", 1'b1, VERDICT_BAD_VERSION, 9'd505},
		'{"GET / HTTP/1.1\015\nhost: a\015\n\015\n", 1'b1, VERDICT_NO_HOST, 9'd418},
		'{"GET /home HTTP/1.1\015\nHost: a\015\n\015\n", 1'b1, VERDICT_BAD_TARGET, 9'd404},
		'{"GET /index.htmlindex.html HTTP/1.1\015\nHost: a\015\n\015\n",
			1'b0, VERDICT_OK, 9'd0},
		'{"GETGETGETGETGETGET / HTTP/1.1\015\nHost: a\015\n\015\n", 1'b0, VERDICT_OK, 9'd0},
		'{"a b c d e f\015\nHost:\015\n\015\n", 1'b0, VERDICT_OK, 9'd0},
		'{"POST / HTTP/1.1\015\nHost: a\015\n\015\nbody\001\377\200 GET\015\n",
			1'b0, VERDICT_OK, 9'd0},
		'{"\tGET\v/\fHTTP/1.1 \015\nHHost:z\015\n\015\n", 1'b0, VERDICT_OK, 9'd0},
		'{"GET\n/ HTTP/1.1\015\nHost: a\015\n\015\n", 1'b0, VERDICT_OK, 9'd0},
		'{"GET / HTTP/1.1\015\nHost: a\015\n", 1'b0, VERDICT_OK, 9'd0},
		'{"\015\n\015\n", 1'b0, VERDICT_OK, 9'd0},
		'{"GET / HTTP/1.1\015\nX-Host: a\015\n\015\n", 1'b0, VERDICT_OK, 9'd0}
	};

	// Return the parser to the start of a request line.
	function automatic void clear_parser();
		region    = REGION_LINE;
		recent    = '0;
		hdr_cnt   = '0;
		words     = '0;
		in_word   = 1'b0;
		char_idx  = '0;
		cands     = '1;
		checks    = '0;
		host_prog = '0;
		host_seen = 1'b0;
	endfunction

	// A candidate matched the whole word just closed.
	function automatic bit cand_full(input int k);
		return cands[k] && (cand_word[k].len() == int'(char_idx));
	endfunction

	// Advance the parser by one accepted byte; returns 1 when a verdict is due.
	function automatic bit predict_byte(input logic [7:0] c, input logic last,
			output verdict_rec_t rec);
		verdict_t v;
		int       k;
		rec = '0;
		if (region == REGION_LINE) begin
			if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
				// A blank closes the current word and records its check.
				if (in_word) begin
					if (words == 3'd1 && (cand_full(CAND_GET) || cand_full(CAND_POST)))
						checks[CHECK_METHOD] = 1'b1;
					else if (words == 3'd2 && (cand_full(CAND_ROOT) || cand_full(CAND_INDEX)))
						checks[CHECK_TARGET] = 1'b1;
					else if (words == 3'd3 && cand_full(CAND_HTTP11))
						checks[CHECK_VERSION] = 1'b1;
					in_word = 1'b0;
				end
			end else begin
				if (!in_word) begin
					in_word = 1'b1;
					if (words != WORD_COUNT_MAX)
						words++;
					char_idx = '0;
					cands    = '1;
				end
				for (k = 0; k < NCAND; k++) begin
					if (int'(char_idx) >= cand_word[k].len() || cand_word[k][char_idx] != c)
						cands[k] = 1'b0;
				end
				if (char_idx != CHAR_INDEX_MAX)
					char_idx++;
			end
			if (recent[7:0] == CHAR_CR && c == CHAR_LF) begin
				region    = REGION_HEADERS;
				hdr_cnt   = '0;
				host_prog = '0;
			end
		end else if (region == REGION_HEADERS) begin
			if (hdr_cnt != HDR_COUNT_MAX)
				hdr_cnt++;
			if (host_prog < HOST_LEN && host_word[host_prog] == c) begin
				host_prog++;
				if (host_prog == HOST_LEN) begin
					host_seen = 1'b1;
					host_prog = '0;
				end
			end else begin
				host_prog = (c == CHAR_H) ? 3'd1 : 3'd0;
			end
			if (recent == CRLFCR && c == CHAR_LF)
				region = (hdr_cnt == 2'd2) ? REGION_BODY_EMPTY : REGION_BODY;
		end
		recent = {recent[15:0], c};
		if (!last)
			return 1'b0;

		// Verdict in order of precedence.
		if (region == REGION_LINE || region == REGION_HEADERS) v = VERDICT_NO_BLANK;
		else if (region == REGION_BODY_EMPTY) v = VERDICT_NO_HEADERS;
		else if (words > 3'd3) v = VERDICT_MANY_WORDS;
		else if (words < 3'd3) v = VERDICT_FEW_WORDS;
		else if (!checks[CHECK_METHOD]) v = VERDICT_BAD_METHOD;
		else if (!checks[CHECK_VERSION]) v = VERDICT_BAD_VERSION;
		else if (!host_seen) v = VERDICT_NO_HOST;
		else if (!checks[CHECK_TARGET]) v = VERDICT_BAD_TARGET;
		else v = VERDICT_OK;
		rec.verdict = v;
		rec.status  = status_tab[v];
		clear_parser();
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatches++;
	endtask

	task automatic push_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			req_bytes.push_back(s[i]);
	endtask

	// Random non-blank word, covering the upper half of the byte range as well.
	task automatic push_word(input int lo, input int hi);
		repeat ($urandom_range(lo, hi))
			req_bytes.push_back(8'($urandom_range(33, 255)));
	endtask

	// Word separator, now and then a bare CR.
	task automatic push_gap();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: req_bytes.push_back(CHAR_SPACE);
			5, 6:          req_bytes.push_back(CHAR_TAB);
			7:             req_bytes.push_back(8'h0B);
			8:             req_bytes.push_back(8'h0C);
			default:       req_bytes.push_back(CHAR_CR);
		endcase
	endtask

	// Word with one character replaced at random.
	task automatic push_mutated(input string s);
		int pos;
		pos = $urandom_range(0, s.len() - 1);
		s[pos] = byte'($urandom_range(33, 126));
		push_text(s);
	endtask

	// Stream the bytes of req_bytes, marking the last, and record the verdict owed.
	task automatic send_request(input bit fixed, input verdict_rec_t fixed_rec);
		verdict_rec_t rec;
		int           i;
		for (i = 0; i < req_bytes.size(); i++) begin
			if (!steady) begin
				while ($urandom_range(0, 99) < IDLE_PERCENT) begin
					request.valid <= 1'b0;
					@(posedge clk);
				end
			end
			request.valid          <= 1'b1;
			request.data_byte      <= req_bytes[i];
			request.end_of_request <= (i == req_bytes.size() - 1);
			@(posedge clk);
			while (!request.ready)
				@(posedge clk);
			if (predict_byte(req_bytes[i], i == req_bytes.size() - 1, rec))
				verdicts_due.push_back(fixed ? fixed_rec : rec);
			bytes_sent++;
		end
	endtask

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit.
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	// Result side: random stalls, a steady stretch, and one long hold-off.
	initial begin : result_sink
		int held;
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				result.ready <= 1'b0;
				for (held = 1; held < HOLD_CYCLES; held++)
					@(posedge clk);
				hold_off = 1'b0;
			end else if (steady) begin
				result.ready <= 1'b1;
			end else begin
				result.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
			end
		end
	end

	// Compare each result transfer with the oldest verdict owed.
	always @(posedge clk) begin : result_check
		verdict_rec_t want;
		if (arst_n && result.valid && result.ready) begin
			if (verdicts_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result, verdict %0d status %0d",
					result.verdict, result.status_number));
			end else begin
				want = verdicts_due.pop_front();
				if (result.verdict !== want.verdict)
					report_mismatch($sformatf("verdict %0d, expected %0d",
						result.verdict, want.verdict));
				if (result.status_number !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						result.status_number, want.status));
			end
		end
	end

	// Reset, directed table, random requests, drain.
	initial begin : stimulus
		verdict_rec_t fixed_rec;
		int           row;
		int           random_reqs;
		int           random_start;
		int           keep;
		request.valid          = 1'b0;
		request.data_byte      = '0;
		request.end_of_request = 1'b0;
		arst_n                 = 1'b0;
		steady                 = 1'b0;
		hold_off               = 1'b0;
		mismatches             = 0;
		bytes_sent             = 0;
		clear_parser();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests.
		for (row = 0; row < $size(probe_rows); row++) begin
			req_bytes.delete();
			push_text(probe_rows[row].text);
			fixed_rec.verdict = probe_rows[row].verdict;
			fixed_rec.status  = probe_rows[row].status;
			send_request(probe_rows[row].fixed, fixed_rec);
		end

		// Random requests; the result side holds off at the start so the block backs up.
		hold_off     = 1'b1;
		random_reqs  = 0;
		random_start = bytes_sent;
		while (bytes_sent - random_start < RANDOM_BYTES || random_reqs < MIN_RANDOM_REQS) begin
			steady = (random_reqs >= 12 && random_reqs < 22);
			req_bytes.delete();
			if ($urandom_range(0, 99) < 8) begin
				// Noise: raw bytes of any value.
				repeat ($urandom_range(1, 12))
					req_bytes.push_back(8'($urandom_range(0, 255)));
			end else begin
				if ($urandom_range(0, 3) == 0)
					push_gap();
				case ($urandom_range(0, 9))
					0, 1, 2, 3: push_text("GET");
					4, 5, 6:    push_text("POST");
					7: begin
						if ($urandom_range(0, 1) != 0)
							push_mutated("GET");
						else
							push_mutated("POST");
					end
					default:    push_word(1, 5);
				endcase
				push_gap();
				case ($urandom_range(0, 9))
					0, 1, 2, 3: push_text("/");
					4, 5, 6:    push_text("/index.html");
					7:          push_mutated("/index.html");
					8:          push_word(1, 6);
					default: begin
						push_text("/index.html");
						push_word(5, 12);
					end
				endcase
				// Usually three words, sometimes two or four.
				keep = $urandom_range(0, 9);
				if (keep != 0) begin
					push_gap();
					case ($urandom_range(0, 9))
						7:       push_mutated("HTTP/1.1");
						8:       push_text("HTTP/1.0");
						9:       push_text("HTTP/1.11");
						default: push_text("HTTP/1.1");
					endcase
				end
				if (keep == 1) begin
					push_gap();
					push_word(1, 4);
				end
				if ($urandom_range(0, 3) == 0)
					push_gap();
				if ($urandom_range(0, 9) == 0)
					push_text("\n");
				push_text("\015\n");
				// Header lines, now and then none at all.
				if ($urandom_range(0, 9) != 0) begin
					repeat ($urandom_range(1, 3)) begin
						case ($urandom_range(0, 5))
							0, 1, 2: begin
								push_text("Host: ");
								push_word(1, 6);
							end
							3:       push_text("Accept: */*");
							4:       push_mutated("Host:");
							default: push_text("X-HHost:");
						endcase
						push_text("\015\n");
					end
				end
				push_text("\015\n");
				if ($urandom_range(0, 3) == 0) begin
					repeat ($urandom_range(1, 10))
						req_bytes.push_back(8'($urandom_range(0, 255)));
				end
				// Cut some requests short anywhere.
				if ($urandom_range(0, 9) == 0) begin
					keep = $urandom_range(1, req_bytes.size() - 1);
					while (req_bytes.size() > keep)
						void'(req_bytes.pop_back());
				end
			end
			send_request(1'b0, '0);
			random_reqs++;
		end
		steady = 1'b0;
		request.valid <= 1'b0;

		// Wait for every verdict owed, then drain for stray transfers.
		while (verdicts_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
